FILE: rtl/core/bounded_stack_with_depth_access_assert.svh
// Assertion macros for the bounded stack.
// ASSERT_IMP checks an implication in the same cycle, ASSERT_NEXT in the cycle after.
`ifndef BOUNDED_STACK_WITH_DEPTH_ACCESS_ASSERT_SVH
`define BOUNDED_STACK_WITH_DEPTH_ACCESS_ASSERT_SVH
`ifndef SYNTH
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stack assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stack assertion failed");
`else
`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/bsda_pkg.sv
package bsda_pkg;

  localparam int CAP_W   = 4;
  localparam int COUNT_W = 4;
  localparam int POS_W   = 4;
  localparam int OP_W    = 3;
  localparam int TAG_W   = 64;
  localparam int NUM_W   = 32;
  localparam int DL_W    = 32;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 4'd5;

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
  localparam logic [OP_W-1:0] OP_CHANGE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    logic [TAG_W-1:0]        tag;
    logic signed [NUM_W-1:0] number;
    logic [DL_W-1:0]         deadline;
  } entry_t;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [TAG_W-1:0]        name_tag;
    logic signed [NUM_W-1:0] task_number;
    logic [DL_W-1:0]         deadline_code;
    logic [POS_W-1:0]        position;
  } req_t;

  typedef struct packed {
    status_t                 status;
    logic [TAG_W-1:0]        read_name_tag;
    logic signed [NUM_W-1:0] read_number;
    logic [DL_W-1:0]         read_deadline;
    logic [COUNT_W-1:0]      entry_count;
    logic                    is_full;
    logic                    is_empty;
  } rsp_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic write;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/bsda_req_if.sv
interface bsda_req_if import bsda_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/bsda_rsp_if.sv
interface bsda_rsp_if import bsda_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/bsda_cell.sv
module bsda_cell import bsda_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     up_in,
  input  entry_t     down_in,
  input  entry_t     wr_in,
  output entry_t     q
);

  // Push shifts the row away from the top, pop shifts it back toward the top.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      q <= up_in;
    end else if (ctrl.pop) begin
      q <= down_in;
    end else if (ctrl.write) begin
      q <= wr_in;
    end
  end

endmodule

FILE: rtl/core/bounded_stack_with_depth_access.sv
// Bounded LIFO stack with peek and change by position from the top.
// Channels: req carries one operation per beat (push, pop, peek, change,
// clear) with the entry fields and a position; rsp carries one result beat
// per request with status, the peeked entry, the count and full/empty flags.
// The user must write the capacity register (cfg_we/cfg_wdata) only while idle.
// The block does not enforce this; each result is registered and appears in the
// cycle after its request is accepted. One request per cycle while results are
// taken; each operation completes in the cycle it is accepted, since each entry
// sits in its own cell and the row of cells shifts by one place on push or pop.
// Peek reads the cell selected by position through one mux over the row.
// Reset clears the count to zero and sets capacity to 5; entry cells are
// left as they are and are only read below the count.
// When the receiver stalls, the result register holds its beat and req.ready
// drops until that beat is taken; a new request is taken in the same cycle
// the held beat leaves.
`include "bounded_stack_with_depth_access_assert.svh"
module bounded_stack_with_depth_access import bsda_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  bsda_req_if.sink         req,
  bsda_rsp_if.source       rsp
);

  logic [CAP_W-1:0]   capacity;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               rsp_valid;
  rsp_t               rsp_data;

  logic               accept;
  logic               full_now;
  logic               full_next;
  logic [POS_W-1:0]   pos_eff;
  logic [POS_W-1:0]   sel;
  logic               pos_ok;
  logic               do_push;
  logic               do_pop;
  logic               do_write;
  logic               rd_en;
  status_t            status;
  entry_t             new_entry;
  entry_t             rd_entry;
  entry_t             cell_q [DEPTH];

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  assign new_entry.tag      = req.data.name_tag;
  assign new_entry.number   = req.data.task_number;
  assign new_entry.deadline = req.data.deadline_code;

  assign full_now = (count >= capacity) || (32'(count) >= DEPTH);
  assign full_next = (count_next >= capacity) || (32'(count_next) >= DEPTH);

  // Positions zero and one both name the top cell.
  assign pos_eff = (req.data.position == '0) ? POS_W'(1) : req.data.position;
  assign pos_ok  = (COUNT_W'(pos_eff) <= count);
  assign sel     = pos_eff - POS_W'(1);

  always_comb begin
    status     = ST_OK;
    count_next = count;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    do_write   = 1'b0;
    rd_en      = 1'b0;
    case (req.data.operation)
      OP_PUSH: begin
        if (full_now) begin
          status = ST_FULL;
        end else begin
          do_push    = 1'b1;
          count_next = count + COUNT_W'(1);
        end
      end
      OP_POP: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else begin
          do_pop     = 1'b1;
          count_next = count - COUNT_W'(1);
        end
      end
      OP_PEEK: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else if (!pos_ok) begin
          status = ST_BADPOS;
        end else begin
          rd_en = 1'b1;
        end
      end
      OP_CHANGE: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else if (!pos_ok) begin
          status = ST_BADPOS;
        end else begin
          do_write = 1'b1;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // Zero unless a peek hits; sel matches at most one cell.
  always_comb begin
    rd_entry = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (rd_en && (32'(sel) == i)) begin
        rd_entry = rd_entry | cell_q[i];
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cell_ctrl_t ctrl;
    entry_t     up_in;
    entry_t     down_in;

    assign ctrl.push  = accept && do_push;
    assign ctrl.pop   = accept && do_pop;
    assign ctrl.write = accept && do_write && (32'(sel) == g);

    if (g == 0) begin : g_top
      assign up_in = new_entry;
    end else begin : g_mid
      assign up_in = cell_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_bottom
      assign down_in = cell_q[g];
    end else begin : g_inner
      assign down_in = cell_q[g+1];
    end

    bsda_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .up_in   (up_in),
      .down_in (down_in),
      .wr_in   (new_entry),
      .q       (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
      count    <= '0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data.status        <= status;
      rsp_data.read_name_tag <= rd_entry.tag;
      rsp_data.read_number   <= rd_entry.number;
      rsp_data.read_deadline <= rd_entry.deadline;
      rsp_data.entry_count   <= count_next;
      rsp_data.is_full       <= full_next;
      rsp_data.is_empty      <= (count_next == '0);
    end
  end

  `ASSERT_IMP(a_count_bounded, clk, rst, 1'b1, 32'(count) <= DEPTH)
  `ASSERT_NEXT(a_push_grows, clk, rst, accept && (req.data.operation == OP_PUSH) && !full_now, count == $past(count) + COUNT_W'(1))
  `ASSERT_NEXT(a_pop_empty, clk, rst, accept && (req.data.operation == OP_POP) && (count == '0), rsp_valid && (rsp_data.status == ST_EMPTY))
  `ASSERT_IMP(a_read_zero, clk, rst, rsp_valid && (rsp_data.status != ST_OK), (rsp_data.read_name_tag == '0) && (rsp_data.read_number == '0) && (rsp_data.read_deadline == '0))

endmodule
